[src/quadratic_root_solver_unit_macros.svh]
// assertion macros for the quadratic root solver
// used by quadratic_root_solver_unit, no other dependencies
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_MACROS_SVH

// pre holds at an edge, post holds at the same edge
`define QRS_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("qrs check failed");

// cond never holds out of reset
`define QRS_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `QRS_ASSERT_IMPLY(lbl, clk, rst_n, 1'b1, !(cond))

`endif

[src/qrs_pkg.sv]
// types and constants of the quadratic root solver
// shared by the cells and the top level, no dependencies
package qrs_pkg;

  localparam int unsigned WordBits   = 32;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned DiscBits   = 2 * WordBits + 2;
  localparam int unsigned RootBits   = WordBits + 1;
  localparam int unsigned SqCells    = DiscBits / 2;
  localparam int unsigned SqRemBits  = RootBits + 2;
  localparam int unsigned SBits      = RootBits + 1;
  localparam int unsigned NumBits    = WordBits + 4;
  localparam int unsigned NMagBits   = WordBits + 3;
  localparam int unsigned DMagBits   = WordBits + 1;
  localparam int unsigned DivBits    = WordBits + 2;
  localparam int unsigned DivRemBits = DivBits + 1;
  localparam int unsigned DivNumBits = NMagBits + FracBits + 2;
  localparam int unsigned NumStages  = 3 + SqCells + 3 + WordBits + 1;

  typedef enum logic [2:0] {
    KIND_TWO_REAL = 3'd0,
    KIND_COMPLEX  = 3'd1,
    KIND_LINEAR   = 3'd2,
    KIND_NONE     = 3'd3,
    KIND_INFINITE = 3'd4
  } root_kind_e;

  typedef struct packed {
    logic signed [WordBits-1:0] coef_a;
    logic signed [WordBits-1:0] coef_b;
    logic signed [WordBits-1:0] coef_c;
  } in_word_t;

  typedef struct packed {
    root_kind_e                 root_kind;
    logic signed [WordBits-1:0] first_value;
    logic signed [WordBits-1:0] second_value;
    logic                       saturated;
  } out_word_t;

  typedef struct packed {
    logic                an;
    logic [WordBits-1:0] am;
    logic                bn;
    logic [WordBits-1:0] bm;
    logic                cn;
    logic [WordBits-1:0] cm;
  } coef_t;

  typedef struct packed {
    coef_t coef;
    logic  disc_neg;
  } sq_side_t;

  typedef struct packed {
    root_kind_e          kind;
    logic [NumBits-1:0]  num_a;
    logic [NumBits-1:0]  num_b;
    logic [DMagBits-1:0] dmag;
    logic                dneg;
  } num_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic ovf;
  } lane_t;

  typedef struct packed {
    root_kind_e kind;
    lane_t      lane_a;
    lane_t      lane_b;
  } div_side_t;

endpackage

[src/qrs_sqrt_cell.sv]
// one cell of the square root chain, one root bit per cell
// depends on qrs_pkg
module qrs_sqrt_cell (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [qrs_pkg::SqRemBits-1:0]   rem_i,
  input  logic [qrs_pkg::RootBits-1:0]    root_i,
  input  logic [qrs_pkg::DiscBits-1:0]    x_i,
  output logic [qrs_pkg::SqRemBits-1:0]   rem_o,
  output logic [qrs_pkg::RootBits-1:0]    root_o,
  output logic [qrs_pkg::DiscBits-1:0]    x_o
);
  import qrs_pkg::*;

  logic [SqRemBits+1:0] pair;
  logic [SqRemBits+1:0] trial;
  logic                 take;
  logic [SqRemBits-1:0] rem_d, rem_q;
  logic [RootBits-1:0]  root_d, root_q;
  logic [DiscBits-1:0]  x_d, x_q;

  always_comb begin
    pair   = {rem_i, x_i[DiscBits-1 -: 2]};
    trial  = (SqRemBits+2)'({root_i, 2'b01});
    take   = pair >= trial;
    rem_d  = take ? SqRemBits'(pair - trial) : SqRemBits'(pair);
    root_d = {root_i[RootBits-2:0], take};
    x_d    = {x_i[DiscBits-3:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      x_q    <= x_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign x_o    = x_q;

endmodule

[src/qrs_div_cell.sv]
// one cell of the restoring divider chain, one quotient bit per cell
// depends on qrs_pkg
module qrs_div_cell (
  input  logic                             clk_i,
  input  logic                             en_i,
  input  logic [qrs_pkg::DivRemBits-1:0]   rem_i,
  input  logic [qrs_pkg::WordBits-1:0]     low_i,
  input  logic [qrs_pkg::DivBits-1:0]      d_i,
  input  logic [qrs_pkg::WordBits-1:0]     q_i,
  output logic [qrs_pkg::DivRemBits-1:0]   rem_o,
  output logic [qrs_pkg::WordBits-1:0]     low_o,
  output logic [qrs_pkg::DivBits-1:0]      d_o,
  output logic [qrs_pkg::WordBits-1:0]     q_o
);
  import qrs_pkg::*;

  logic [DivRemBits-1:0] t;
  logic                  take;
  logic [DivRemBits-1:0] rem_d, rem_q;
  logic [WordBits-1:0]   low_d, low_q;
  logic [WordBits-1:0]   q_d, q_q;
  logic [DivBits-1:0]    d_q;

  always_comb begin
    t     = {rem_i[DivRemBits-2:0], low_i[WordBits-1]};
    take  = t >= DivRemBits'(d_i);
    rem_d = take ? (t - DivRemBits'(d_i)) : t;
    low_d = {low_i[WordBits-2:0], 1'b0};
    q_d   = {q_i[WordBits-2:0], take};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      low_q <= low_d;
      q_q   <= q_d;
      d_q   <= d_i;
    end
  end

  assign rem_o = rem_q;
  assign low_o = low_q;
  assign d_o   = d_q;
  assign q_o   = q_q;

endmodule

[src/quadratic_root_solver_unit.sv]
// quadratic root solver top level: input split, discriminant, root and divider chains
// depends on qrs_pkg, qrs_sqrt_cell, qrs_div_cell and the assertion macro header
//
// Takes one coefficient word per cycle and returns one result word per cycle while the output is
// not stalled. The pipe holds registers for sign split, products and the exact discriminant, 33
// square root cells of one root bit each, registers for rounding, numerator setup and
// divider setup, 32 divider cells of one quotient bit each (two lanes side by side), and
// the output register. The whole pipe advances whenever the output register is empty or
// being taken, so a stalled output holds every stage in place.
`include "quadratic_root_solver_unit_macros.svh"

module quadratic_root_solver_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  qrs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output qrs_pkg::out_word_t out_word_o
);
  import qrs_pkg::*;

  typedef struct packed {
    lane_t                 flags;
    logic [DivRemBits-1:0] rem;
    logic [WordBits-1:0]   low;
  } prep_t;

  function automatic logic [WordBits-1:0] mag_of(logic [WordBits-1:0] v);
    return v[WordBits-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic prep_t prep_lane(logic [NumBits-1:0] n, logic dneg,
                                      logic [DMagBits-1:0] dmag);
    logic                  nneg;
    logic [NMagBits-1:0]   nmag;
    logic [DivNumBits-1:0] numv;
    logic [DivBits-1:0]    dv;
    prep_t                 p;
    nneg         = n[NumBits-1];
    nmag         = NMagBits'(nneg ? (NumBits'(0) - n) : n);
    numv         = DivNumBits'({nmag, (FracBits+1)'(0)}) + DivNumBits'(dmag);
    dv           = {dmag, 1'b0};
    p.flags.neg  = nneg ^ dneg;
    p.flags.zero = (nmag == '0);
    p.flags.ovf  = (DivBits+WordBits)'(numv) >= {dv, WordBits'(0)};
    p.rem        = DivRemBits'(numv[DivNumBits-1:WordBits]);
    p.low        = numv[WordBits-1:0];
    return p;
  endfunction

  function automatic logic [WordBits:0] finish_lane(lane_t f, logic [WordBits-1:0] q);
    logic [WordBits-1:0] limit;
    logic [WordBits-1:0] mag;
    logic                sat;
    limit = {1'b0, {(WordBits-1){1'b1}}} + WordBits'(f.neg);
    sat   = 1'b0;
    mag   = q;
    if (f.zero) begin
      mag = '0;
    end else if (f.ovf || (q > limit)) begin
      mag = limit;
      sat = 1'b1;
    end
    return {sat, f.neg ? (WordBits'(0) - mag) : mag};
  endfunction

  // pipe control
  logic                 en;
  logic [NumStages-1:0] vld_q;

  assign en          = !vld_q[NumStages-1] || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NumStages-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NumStages-2:0], in_valid_i};
    end
  end

  // sign split
  coef_t coef_d, coef_q;

  always_comb begin
    coef_d.an = in_word_i.coef_a[WordBits-1];
    coef_d.am = mag_of(in_word_i.coef_a);
    coef_d.bn = in_word_i.coef_b[WordBits-1];
    coef_d.bm = mag_of(in_word_i.coef_b);
    coef_d.cn = in_word_i.coef_c[WordBits-1];
    coef_d.cm = mag_of(in_word_i.coef_c);
  end

  always_ff @(posedge clk_i) begin
    if (en) coef_q <= coef_d;
  end

  // products
  logic [2*WordBits-1:0] bb_d, ac_d, bb_q, ac_q;
  coef_t                 coef_m_q;

  assign bb_d = coef_q.bm * coef_q.bm;
  assign ac_d = coef_q.am * coef_q.cm;

  always_ff @(posedge clk_i) begin
    if (en) begin
      bb_q     <= bb_d;
      ac_q     <= ac_d;
      coef_m_q <= coef_q;
    end
  end

  // discriminant
  logic [DiscBits-1:0] p_w, q4_w, disc_d, disc_q;
  logic                disc_neg_d;
  sq_side_t            disc_side_q;

  always_comb begin
    p_w        = DiscBits'(bb_q);
    q4_w       = {ac_q, 2'b00};
    disc_neg_d = 1'b0;
    if (coef_m_q.an != coef_m_q.cn) begin
      disc_d = p_w + q4_w;
    end else if (p_w < q4_w) begin
      disc_d     = q4_w - p_w;
      disc_neg_d = 1'b1;
    end else begin
      disc_d = p_w - q4_w;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      disc_q               <= disc_d;
      disc_side_q.coef     <= coef_m_q;
      disc_side_q.disc_neg <= disc_neg_d;
    end
  end

  // square root chain
  logic [SqRemBits-1:0] sq_rem  [SqCells];
  logic [RootBits-1:0]  sq_root [SqCells];
  logic [DiscBits-1:0]  sq_x    [SqCells];
  sq_side_t             sq_side_q [SqCells];

  for (genvar k = 0; k < SqCells; k++) begin : g_sq
    if (k == 0) begin : g_first
      qrs_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  ('0),
        .root_i ('0),
        .x_i    (disc_q),
        .rem_o  (sq_rem[k]),
        .root_o (sq_root[k]),
        .x_o    (sq_x[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) sq_side_q[k] <= disc_side_q;
      end
    end else begin : g_next
      qrs_sqrt_cell u_cell (
        .clk_i  (clk_i),
        .en_i   (en),
        .rem_i  (sq_rem[k-1]),
        .root_i (sq_root[k-1]),
        .x_i    (sq_x[k-1]),
        .rem_o  (sq_rem[k]),
        .root_o (sq_root[k]),
        .x_o    (sq_x[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) sq_side_q[k] <= sq_side_q[k-1];
      end
    end
  end

  // round to nearest
  logic [SBits-1:0] s_d, s_q;
  sq_side_t         rnd_side_q;

  assign s_d = SBits'(sq_root[SqCells-1])
             + SBits'(sq_rem[SqCells-1] > SqRemBits'(sq_root[SqCells-1]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q        <= s_d;
      rnd_side_q <= sq_side_q[SqCells-1];
    end
  end

  // numerators and divisor
  logic [NumBits-1:0] sb_w, sc_w, sv_w;
  num_t               num_d, num_q;

  always_comb begin
    sb_w = rnd_side_q.coef.bn ? (NumBits'(0) - NumBits'(rnd_side_q.coef.bm))
                              : NumBits'(rnd_side_q.coef.bm);
    sc_w = rnd_side_q.coef.cn ? (NumBits'(0) - NumBits'(rnd_side_q.coef.cm))
                              : NumBits'(rnd_side_q.coef.cm);
    sv_w = NumBits'(s_q);
    num_d.dmag  = {rnd_side_q.coef.am, 1'b0};
    num_d.dneg  = rnd_side_q.coef.an;
    num_d.num_a = '0;
    num_d.num_b = '0;
    if (rnd_side_q.coef.am != '0) begin
      if (rnd_side_q.disc_neg) begin
        num_d.kind  = KIND_COMPLEX;
        num_d.num_a = NumBits'(0) - sb_w;
        num_d.num_b = sv_w;
      end else begin
        num_d.kind  = KIND_TWO_REAL;
        num_d.num_a = sv_w - sb_w;
        num_d.num_b = NumBits'(0) - sb_w - sv_w;
      end
    end else if (rnd_side_q.coef.bm != '0) begin
      num_d.kind  = KIND_LINEAR;
      num_d.num_a = NumBits'(0) - sc_w;
      num_d.dmag  = DMagBits'(rnd_side_q.coef.bm);
      num_d.dneg  = rnd_side_q.coef.bn;
    end else begin
      num_d.kind = (rnd_side_q.coef.cm != '0) ? KIND_NONE : KIND_INFINITE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) num_q <= num_d;
  end

  // divider setup, imaginary part divides by the magnitude of 2a
  prep_t              prep_a_q, prep_b_q;
  logic [DivBits-1:0] dv_q;
  root_kind_e         prep_kind_q;
  logic               dneg_b;

  assign dneg_b = num_q.dneg && (num_q.kind != KIND_COMPLEX);

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_a_q    <= prep_lane(num_q.num_a, num_q.dneg, num_q.dmag);
      prep_b_q    <= prep_lane(num_q.num_b, dneg_b, num_q.dmag);
      dv_q        <= {num_q.dmag, 1'b0};
      prep_kind_q <= num_q.kind;
    end
  end

  // divider chains, lanes a and b
  logic [DivRemBits-1:0] da_rem [WordBits];
  logic [WordBits-1:0]   da_low [WordBits];
  logic [DivBits-1:0]    da_d   [WordBits];
  logic [WordBits-1:0]   da_q   [WordBits];
  logic [DivRemBits-1:0] db_rem [WordBits];
  logic [WordBits-1:0]   db_low [WordBits];
  logic [DivBits-1:0]    db_d   [WordBits];
  logic [WordBits-1:0]   db_q   [WordBits];
  div_side_t             dv_side_q [WordBits];

  for (genvar k = 0; k < WordBits; k++) begin : g_div
    if (k == 0) begin : g_first
      qrs_div_cell u_cell_a (
        .clk_i (clk_i), .en_i (en),
        .rem_i (prep_a_q.rem), .low_i (prep_a_q.low), .d_i (dv_q), .q_i ('0),
        .rem_o (da_rem[k]), .low_o (da_low[k]), .d_o (da_d[k]), .q_o (da_q[k])
      );
      qrs_div_cell u_cell_b (
        .clk_i (clk_i), .en_i (en),
        .rem_i (prep_b_q.rem), .low_i (prep_b_q.low), .d_i (dv_q), .q_i ('0),
        .rem_o (db_rem[k]), .low_o (db_low[k]), .d_o (db_d[k]), .q_o (db_q[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) begin
          dv_side_q[k].kind   <= prep_kind_q;
          dv_side_q[k].lane_a <= prep_a_q.flags;
          dv_side_q[k].lane_b <= prep_b_q.flags;
        end
      end
    end else begin : g_next
      qrs_div_cell u_cell_a (
        .clk_i (clk_i), .en_i (en),
        .rem_i (da_rem[k-1]), .low_i (da_low[k-1]), .d_i (da_d[k-1]), .q_i (da_q[k-1]),
        .rem_o (da_rem[k]), .low_o (da_low[k]), .d_o (da_d[k]), .q_o (da_q[k])
      );
      qrs_div_cell u_cell_b (
        .clk_i (clk_i), .en_i (en),
        .rem_i (db_rem[k-1]), .low_i (db_low[k-1]), .d_i (db_d[k-1]), .q_i (db_q[k-1]),
        .rem_o (db_rem[k]), .low_o (db_low[k]), .d_o (db_d[k]), .q_o (db_q[k])
      );
      always_ff @(posedge clk_i) begin
        if (en) dv_side_q[k] <= dv_side_q[k-1];
      end
    end
  end

  // saturation and output register
  logic [WordBits:0] fin_a, fin_b;
  out_word_t         out_d, out_q;

  always_comb begin
    fin_a              = finish_lane(dv_side_q[WordBits-1].lane_a, da_q[WordBits-1]);
    fin_b              = finish_lane(dv_side_q[WordBits-1].lane_b, db_q[WordBits-1]);
    out_d.root_kind    = dv_side_q[WordBits-1].kind;
    out_d.first_value  = fin_a[WordBits-1:0];
    out_d.second_value = fin_b[WordBits-1:0];
    out_d.saturated    = fin_a[WordBits] | fin_b[WordBits];
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= out_d;
  end

  assign out_word_o = out_q;

  logic out_trivial, out_linear, out_complex, out_all_zero;

  assign out_trivial  = out_valid_o && (out_word_o.root_kind == KIND_NONE ||
                                        out_word_o.root_kind == KIND_INFINITE);
  assign out_linear   = out_valid_o && out_word_o.root_kind == KIND_LINEAR;
  assign out_complex  = out_valid_o && out_word_o.root_kind == KIND_COMPLEX;
  assign out_all_zero = out_word_o.first_value == '0 && out_word_o.second_value == '0 &&
                        !out_word_o.saturated;

  `QRS_ASSERT_IMPLY(a_trivial_kinds_zero, clk_i, rst_ni, out_trivial, out_all_zero)
  `QRS_ASSERT_IMPLY(a_linear_second_zero, clk_i, rst_ni, out_linear, out_word_o.second_value == '0)
  `QRS_ASSERT_NEVER(a_complex_imag_neg, clk_i, rst_ni, out_complex && out_word_o.second_value[WordBits-1])

endmodule

[test/quadratic_root_solver_unit_test.sv]
`timescale 1ns / 100ps
// testbench for quadratic_root_solver_unit: drives coefficient words, predicts each root word
// with an exact wide-integer model and compares it; depends on qrs_pkg and the solver RTL
module quadratic_root_solver_unit_test;
  import qrs_pkg::*;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  out_word_t expected_roots[$];
  int        errors    = 0;
  int        n_checked = 0;
  int        n_sent    = 0;
  int        idle_pct  = 0;
  int        stall_pct = 0;

  quadratic_root_solver_unit i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_word_o (out_word_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("quadratic_root_solver_unit_test failed");
    $finish;
  end

  // rounded quotient n / d, saturated to the word
  function automatic logic [31:0] round_div(longint n, bit dneg, logic [63:0] dmag,
                                            inout bit sat);
    logic [127:0] nmag;
    logic [127:0] q;
    logic [127:0] limit;
    bit           neg;
    nmag  = (n < 0) ? 128'(-n) : 128'(n);
    neg   = (n < 0) != dneg;
    if (nmag == 0 || dmag == 0) return 32'd0;
    q     = ((nmag << (FracBits + 1)) + 128'(dmag)) / (128'(dmag) << 1);
    limit = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > limit) begin
      q   = limit;
      sat = 1'b1;
    end
    return neg ? -q[31:0] : q[31:0];
  endfunction

  function automatic longint round_sqrt(logic [127:0] x);
    logic [127:0] r;
    logic [127:0] t;
    r = '0;
    for (int i = 40; i >= 0; i--) begin
      t = r | (128'd1 << i);
      if (t * t <= x) r = t;
    end
    if (x - r * r > r) r = r + 1;
    return longint'(r[63:0]);
  endfunction

  function automatic out_word_t solve_roots(in_word_t w);
    out_word_t    res;
    bit           an, bn, cn, dneg, sat;
    logic [63:0]  am, bm, cm;
    logic [127:0] p, q, d;
    longint       sb, sc, s;
    an  = w.coef_a[31];
    bn  = w.coef_b[31];
    cn  = w.coef_c[31];
    am  = an ? 64'(-w.coef_a) & 64'hffff_ffff : 64'(w.coef_a) & 64'hffff_ffff;
    bm  = bn ? 64'(-w.coef_b) & 64'hffff_ffff : 64'(w.coef_b) & 64'hffff_ffff;
    cm  = cn ? 64'(-w.coef_c) & 64'hffff_ffff : 64'(w.coef_c) & 64'hffff_ffff;
    sb  = bn ? -longint'(bm) : longint'(bm);
    sc  = cn ? -longint'(cm) : longint'(cm);
    sat = 1'b0;
    dneg = 1'b0;
    res = '0;
    if (am != 0) begin
      p = 128'(bm) * 128'(bm);
      q = (128'(am) * 128'(cm)) << 2;
      if (an != cn) d = p + q;
      else if (p < q) begin
        d    = q - p;
        dneg = 1'b1;
      end else d = p - q;
      s = round_sqrt(d);
      if (dneg) begin
        res.root_kind    = KIND_COMPLEX;
        res.first_value  = round_div(-sb, an, am << 1, sat);
        res.second_value = round_div(s, 1'b0, am << 1, sat);
      end else begin
        res.root_kind    = KIND_TWO_REAL;
        res.first_value  = round_div(-sb + s, an, am << 1, sat);
        res.second_value = round_div(-sb - s, an, am << 1, sat);
      end
    end else if (bm != 0) begin
      res.root_kind   = KIND_LINEAR;
      res.first_value = round_div(-sc, bn, bm, sat);
    end else begin
      res.root_kind = (cm != 0) ? KIND_NONE : KIND_INFINITE;
    end
    res.saturated = sat;
    return res;
  endfunction

  // inputs only move at rising edges, so the falling edge sees what the next edge takes
  always @(negedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) expected_roots.push_back(solve_roots(in_word_i));
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_roots.size() == 0) begin
        $error("unexpected word: kind %0d", out_word_o.root_kind);
        errors++;
      end else begin
        out_word_t e;
        e = expected_roots.pop_front();
        n_checked++;
        if (out_word_o.root_kind !== e.root_kind) begin
          $error("root_kind exp %0d got %0d", e.root_kind, out_word_o.root_kind);
          errors++;
        end
        if (out_word_o.first_value !== e.first_value) begin
          $error("first_value exp %h got %h", e.first_value, out_word_o.first_value);
          errors++;
        end
        if (out_word_o.second_value !== e.second_value) begin
          $error("second_value exp %h got %h", e.second_value, out_word_o.second_value);
          errors++;
        end
        if (out_word_o.saturated !== e.saturated) begin
          $error("saturated exp %0b got %0b", e.saturated, out_word_o.saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  task automatic send_word(logic [31:0] a, logic [31:0] b, logic [31:0] c);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= '{coef_a: a, coef_b: b, coef_c: c};
    forever begin
      @(negedge clk_i);
      if (!in_stall_o) break;
    end
    @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_roots.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_coef();
    unique case ($urandom_range(5))
      0:       return $urandom;
      1:       return 32'($signed($urandom_range(2000))) - 32'sd1000;
      2:       return {{8{1'($urandom_range(1))}}, 24'($urandom)};
      3:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      4:       return 32'd0;
      default: return 32'($signed($urandom_range(20 << 16))) - (32'sd10 << 16);
    endcase
  endfunction

  task automatic test_special_cases();
    send_word(32'h0001_0000, 32'h0002_0000, 32'h0001_0000);
    send_word(32'h0001_0000, 32'h0000_0000, 32'hfffc_0000);
    send_word(32'h0001_0000, 32'h0000_0000, 32'h0004_0000);
    send_word(32'h0002_0000, 32'h0001_0000, 32'h0003_0000);
    send_word(32'h0000_0000, 32'h0002_0000, 32'hfffa_0000);
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0005_0000);
    send_word(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_word(32'h0000_0000, 32'h0000_0001, 32'h7fff_ffff);
    send_word(32'h0000_0001, 32'h8000_0000, 32'h0000_0000);
    send_word(32'h0000_0001, 32'h0000_0000, 32'h8000_0000);
    send_word(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    send_word(32'hffff_ffff, 32'h0000_0000, 32'h7fff_ffff);
    send_word(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    send_word(32'h0000_0000, 32'hffff_ffff, 32'h8000_0000);
    send_word(32'h7fff_ffff, 32'h0000_0000, 32'h0000_0000);
    send_word(32'hfffe_0000, 32'h0001_0000, 32'hfffd_0000);
    drain();
  endtask

  task automatic test_random_phase(int idle, int stall, int n);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_word(pick_coef(), pick_coef(), pick_coef());
      if (i == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_word_i   <= '0;
    out_stall_i <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_cases();
    test_random_phase(0, 0, 310);
    test_random_phase(50, 0, 310);
    test_random_phase(0, 50, 310);
    test_random_phase(35, 35, 310);
    stall_pct = 0;
    repeat (100) @(posedge clk_i);
    $display("sent %0d coefficient words, checked %0d root words", n_sent, n_checked);
    $display("covered all root kinds, extremes and saturation under four handshake mixes");
    if (errors == 0 && expected_roots.size() == 0) begin
      $display("quadratic_root_solver_unit_test passed");
    end else begin
      $display("quadratic_root_solver_unit_test failed");
    end
    $finish;
  end

endmodule
